// ----- sv/vfc_pkg.sv -----
package vfc_pkg;

  localparam int DEF_VOLUME_BITS = 16;
  localparam int DEF_TICK_BITS   = 16;

  // input event kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_PLAY  = 2'd1,
    KIND_PAUSE = 2'd2,
    KIND_STOP  = 2'd3
  } kind_t;

  // armed transport command, same encoding as the event kinds
  typedef enum logic [1:0] {
    CMD_IDLE  = 2'd0,
    CMD_PLAY  = 2'd1,
    CMD_PAUSE = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE        = 2'd0,
    ACT_START       = 2'd1,
    ACT_STOP        = 2'd2,
    ACT_STOP_REWIND = 2'd3
  } action_t;

  // configuration register indexes
  localparam logic [1:0] CFG_FADE_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_FADE_TICKS    = 2'd1;
  localparam logic [1:0] CFG_TARGET_VOLUME = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WRITE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_t;

endpackage

// ----- sv/vfc_muldiv.sv -----
// bit-serial unit: quot = mult_a * vol_b / divisor
// requires mult_a * vol_b < divisor * 2**VOLUME_BITS so the quotient fits
module vfc_muldiv #(
  parameter int VOLUME_BITS = vfc_pkg::DEF_VOLUME_BITS,
  parameter int TICK_BITS   = vfc_pkg::DEF_TICK_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [TICK_BITS-1:0]   mult_a,
  input  logic [VOLUME_BITS-1:0] vol_b,
  input  logic [TICK_BITS-1:0]   divisor,
  output logic                   done,
  output logic [VOLUME_BITS-1:0] quot
);

  localparam int CW = $clog2(VOLUME_BITS);

  vfc_pkg::md_phase_t phase, phase_next;

  logic [CW-1:0]          cnt;
  logic [TICK_BITS:0]     hi;
  logic [VOLUME_BITS-1:0] lo;
  logic [TICK_BITS-1:0]   m_reg;
  logic [TICK_BITS-1:0]   d_reg;

  logic [TICK_BITS:0] sum;
  logic [TICK_BITS:0] trial;
  logic [TICK_BITS:0] diff;
  logic               ge;
  logic               last;

  always_comb begin
    sum   = hi + {1'b0, m_reg};
    trial = {hi[TICK_BITS-1:0], lo[VOLUME_BITS-1]};
    ge    = trial >= {1'b0, d_reg};
    diff  = trial - {1'b0, d_reg};
    last  = cnt == CW'(VOLUME_BITS - 1);
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      vfc_pkg::MD_IDLE: begin
        if (start) phase_next = vfc_pkg::MD_MUL;
      end
      vfc_pkg::MD_MUL: begin
        if (last) phase_next = vfc_pkg::MD_DIV;
      end
      vfc_pkg::MD_DIV: begin
        if (last) phase_next = vfc_pkg::MD_IDLE;
      end
      default: phase_next = vfc_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= vfc_pkg::MD_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == vfc_pkg::MD_DIV) && last;
      if (phase == vfc_pkg::MD_IDLE || last) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  // one shift register: product builds lsb first into hi/lo, then the
  // remainder sits in hi while quotient bits shift into lo
  always_ff @(posedge clk) begin
    if (start && phase == vfc_pkg::MD_IDLE) begin
      hi    <= '0;
      lo    <= vol_b;
      m_reg <= mult_a;
      d_reg <= divisor;
    end else if (phase == vfc_pkg::MD_MUL) begin
      if (lo[0]) begin
        hi <= {1'b0, sum[TICK_BITS:1]};
        lo <= {sum[0], lo[VOLUME_BITS-1:1]};
      end else begin
        hi <= {1'b0, hi[TICK_BITS:1]};
        lo <= {hi[0], lo[VOLUME_BITS-1:1]};
      end
    end else if (phase == vfc_pkg::MD_DIV) begin
      hi <= ge ? diff : trial;
      lo <= {lo[VOLUME_BITS-2:0], ge};
    end
  end

  assign quot = lo;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> phase == vfc_pkg::MD_IDLE)
    else $error("muldiv started while busy");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (phase == vfc_pkg::MD_DIV) |-> hi < {1'b0, d_reg})
    else $error("division remainder not below divisor");

endmodule

// ----- sv/volume_fade_controller.sv -----
// channel  direction  handshake            payload
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
// in       in         in_valid/in_stall    kind, tick_amount
// out      out        out_valid/out_stall  volume_out, volume_write, transport_action, fading
//
// play/pause/stop events give no transaction on out
// a tick with a ready answer goes straight to the write state; a tick inside a ramp
// first waits in the calc state for the bit-serial multiply then divide unit
// the next item is taken once the result sits in the output register
// rst is synchronous; registers reset to fade on, 1 tick, full target volume
module volume_fade_controller #(
  parameter int VOLUME_BITS = vfc_pkg::DEF_VOLUME_BITS,
  parameter int TICK_BITS   = vfc_pkg::DEF_TICK_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [((VOLUME_BITS > TICK_BITS) ? VOLUME_BITS : TICK_BITS)-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             kind,
  input  logic [TICK_BITS-1:0]   tick_amount,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VOLUME_BITS-1:0] volume_out,
  output logic                   volume_write,
  output logic [1:0]             transport_action,
  output logic                   fading
);

  vfc_pkg::ctrl_state_t state, state_next;

  logic                   fade_enable;
  logic [TICK_BITS-1:0]   fade_ticks;
  logic [VOLUME_BITS-1:0] target_volume;

  vfc_pkg::cmd_t          pending, pending_next;
  logic [TICK_BITS:0]     elapsed, elapsed_next;
  logic [VOLUME_BITS-1:0] start_volume, start_volume_next;
  logic [VOLUME_BITS-1:0] current_volume, current_volume_next;

  logic                   res_write, res_write_next;
  vfc_pkg::action_t       res_action, res_action_next;
  logic                   res_fading, res_fading_next;

  logic                   in_accept;
  logic                   out_free;
  logic                   calc;
  logic [TICK_BITS-1:0]   len;
  logic [TICK_BITS:0]     e_sum;
  logic                   fits;
  logic                   e_lt;
  logic [TICK_BITS-1:0]   md_m;
  logic [VOLUME_BITS-1:0] md_vol;
  logic                   md_done;
  logic [VOLUME_BITS-1:0] md_quot;

  assign cfg_ready = 1'b1;
  assign in_stall  = state != vfc_pkg::ST_IDLE;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    len   = (fade_ticks == '0) ? {{(TICK_BITS-1){1'b0}}, 1'b1} : fade_ticks;
    e_sum = elapsed + {1'b0, tick_amount};
    fits  = elapsed <= {1'b0, fade_ticks};
    e_lt  = e_sum < {1'b0, len};
  end

  // effect of one accepted item on the fade state
  always_comb begin
    pending_next        = pending;
    elapsed_next        = elapsed;
    start_volume_next   = start_volume;
    current_volume_next = current_volume;
    res_write_next      = 1'b0;
    res_action_next     = vfc_pkg::ACT_NONE;
    res_fading_next     = 1'b0;
    calc                = 1'b0;
    md_m                = e_sum[TICK_BITS-1:0];
    md_vol              = target_volume;
    if (kind != vfc_pkg::KIND_TICK) begin
      pending_next = vfc_pkg::cmd_t'(kind);
      elapsed_next = '0;
    end else if (!fade_enable) begin
      res_action_next = vfc_pkg::action_t'(pending);
    end else begin
      case (pending) inside
        vfc_pkg::CMD_IDLE: begin
        end
        vfc_pkg::CMD_PLAY: begin
          if (elapsed == '0) res_action_next = vfc_pkg::ACT_START;
          if (fits) begin
            elapsed_next    = e_sum;
            res_write_next  = 1'b1;
            res_fading_next = 1'b1;
            // at or past the fade length the ramp is clamped to target
            if (e_lt) begin
              calc = 1'b1;
            end else begin
              current_volume_next = target_volume;
            end
          end else begin
            elapsed_next = '0;
            pending_next = vfc_pkg::CMD_IDLE;
          end
        end
        vfc_pkg::CMD_PAUSE, vfc_pkg::CMD_STOP: begin
          if (elapsed == '0) start_volume_next = current_volume;
          if (fits) begin
            elapsed_next    = e_sum;
            res_write_next  = 1'b1;
            res_fading_next = 1'b1;
            md_m            = len - e_sum[TICK_BITS-1:0];
            md_vol          = (elapsed == '0) ? current_volume : start_volume;
            if (e_lt) begin
              calc = 1'b1;
            end else begin
              current_volume_next = '0;
            end
          end else begin
            res_action_next = vfc_pkg::action_t'(pending);
            elapsed_next    = '0;
            pending_next    = vfc_pkg::CMD_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      vfc_pkg::ST_IDLE: begin
        if (in_accept && kind == vfc_pkg::KIND_TICK) begin
          state_next = calc ? vfc_pkg::ST_CALC : vfc_pkg::ST_WRITE;
        end
      end
      vfc_pkg::ST_CALC: begin
        if (md_done) state_next = vfc_pkg::ST_WRITE;
      end
      vfc_pkg::ST_WRITE: begin
        if (out_free) state_next = vfc_pkg::ST_IDLE;
      end
      default: state_next = vfc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= vfc_pkg::ST_IDLE;
      fade_enable    <= 1'b1;
      fade_ticks     <= {{(TICK_BITS-1){1'b0}}, 1'b1};
      target_volume  <= '1;
      pending        <= vfc_pkg::CMD_IDLE;
      elapsed        <= '0;
      start_volume   <= '1;
      current_volume <= '1;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vfc_pkg::CFG_FADE_ENABLE:   fade_enable   <= cfg_data[0];
          vfc_pkg::CFG_FADE_TICKS:    fade_ticks    <= cfg_data[TICK_BITS-1:0];
          vfc_pkg::CFG_TARGET_VOLUME: target_volume <= cfg_data[VOLUME_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        pending        <= pending_next;
        elapsed        <= elapsed_next;
        start_volume   <= start_volume_next;
        current_volume <= current_volume_next;
      end else if (state == vfc_pkg::ST_CALC && md_done) begin
        current_volume <= md_quot;
      end
      if (state == vfc_pkg::ST_WRITE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_write  <= res_write_next;
      res_action <= res_action_next;
      res_fading <= res_fading_next;
    end
    if (state == vfc_pkg::ST_WRITE && out_free) begin
      volume_out       <= current_volume;
      volume_write     <= res_write;
      transport_action <= res_action;
      fading           <= res_fading;
    end
  end

  vfc_muldiv #(
    .VOLUME_BITS(VOLUME_BITS),
    .TICK_BITS  (TICK_BITS)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (in_accept && kind == vfc_pkg::KIND_TICK && calc),
    .mult_a (md_m),
    .vol_b  (md_vol),
    .divisor(len),
    .done   (md_done),
    .quot   (md_quot)
  );

  a_load_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == vfc_pkg::ST_WRITE))
    else $error("result loaded outside write state");

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    md_done |-> state == vfc_pkg::ST_CALC)
    else $error("muldiv finished with no tick waiting");

  a_fadein_clamp: assert property (@(posedge clk) disable iff (rst)
    (state == vfc_pkg::ST_WRITE && res_write && pending == vfc_pkg::CMD_PLAY)
      |-> current_volume <= target_volume)
    else $error("fade-in volume above target");

  a_no_write_when_off: assert property (@(posedge clk) disable iff (rst)
    (state == vfc_pkg::ST_WRITE && !fade_enable) |-> !res_write)
    else $error("volume write with fading disabled");

endmodule
